@@ src/sfm_pkg.sv @@
// Shared types and constants for the servo failsafe mux sequencer.
// Used by sfm_train and servo_failsafe_mux_sequencer_top; no dependencies.
package sfm_pkg;

	localparam int NUM_CHANNELS = 8;
	localparam int NUM_SLOTS    = 4;
	localparam int CH_W         = 4;
	localparam int PW_W         = 15;
	localparam int SLOT_W       = 16;
	localparam int SLOT_IDX_W   = 2;
	localparam int TMO_W        = 8;
	localparam int CHIDX_W      = 3;
	localparam int PADDR_W      = 5;

	// Operation codes of an input word.
	localparam logic [2:0] OP_TICK        = 3'd0;
	localparam logic [2:0] OP_FRAME       = 3'd1;
	localparam logic [2:0] OP_RADIO_WRITE = 3'd2;
	localparam logic [2:0] OP_OUT_WRITE   = 3'd3;
	localparam logic [2:0] OP_LINK_MSG    = 3'd4;

	// Register indexes (byte address is four times the index).
	localparam logic [2:0] REG_COMM_TIMEOUT = 3'd0;
	localparam logic [2:0] REG_FS_CHANNEL   = 3'd1;
	localparam logic [2:0] REG_FS_MIN       = 3'd2;
	localparam logic [2:0] REG_FS_MAX       = 3'd3;
	localparam logic [2:0] REG_MODE_CHANNEL = 3'd4;
	localparam logic [2:0] REG_MODE_THRESH  = 3'd5;
	localparam logic [2:0] REG_EMPTY_TICKS  = 3'd6;

	// Register reset values.
	localparam logic [TMO_W-1:0]  RST_COMM_TIMEOUT = 8'd10;
	localparam logic [CH_W-1:0]   RST_FS_CHANNEL   = 4'd5;
	localparam logic [PW_W-1:0]   RST_FS_MIN       = 15'd2000;
	localparam logic [PW_W-1:0]   RST_FS_MAX       = 15'd4000;
	localparam logic [CH_W-1:0]   RST_MODE_CHANNEL = 4'd6;
	localparam logic [PW_W-1:0]   RST_MODE_THRESH  = 15'd2500;
	localparam logic [SLOT_W-1:0] RST_EMPTY_TICKS  = 16'd100;

	typedef struct packed {
		logic [2:0]      op;
		logic [CH_W-1:0] channel;
		logic [PW_W-1:0] width;
		logic            radio_frame_good;
		logic            failsafe_received;
	} item_t;

	typedef struct packed {
		logic [NUM_SLOTS-1:0] pulse_pins;
		logic [PW_W-1:0]      duty_a;
		logic [PW_W-1:0]      duty_b;
		logic [PW_W-1:0]      duty_c;
		logic [PW_W-1:0]      duty_d;
		logic                 comm_ok;
		logic                 failsafe_good;
		logic                 passthrough_on;
		logic                 outputs_active;
		logic                 sequencing;
	} result_t;

	// Control from the top level to the pulse train for one word.
	typedef struct packed {
		logic tick;
		logic start;
	} train_ctl_t;

	typedef logic [PW_W-1:0] width_t;

endpackage

@@ src/sfm_train.sv @@
// Four-slot serial pulse train for output channels 8, 6, 4 and 2.
// Depends on sfm_pkg for widths and the control struct.
module sfm_train (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sfm_pkg::train_ctl_t                 ctl,
	input  sfm_pkg::width_t [sfm_pkg::NUM_SLOTS-1:0] slot_w,
	input  logic [sfm_pkg::SLOT_W-1:0]          empty_ticks,
	output logic [sfm_pkg::NUM_SLOTS-1:0]       pins_next,
	output logic                                running_next
);

	logic [sfm_pkg::SLOT_IDX_W-1:0] idx_q, idx_d;
	logic [sfm_pkg::SLOT_W-1:0]     rem_q, rem_d;
	logic [sfm_pkg::NUM_SLOTS-1:0]  pins_q, pins_d;
	logic                           run_q, run_d;
	logic [sfm_pkg::SLOT_IDX_W-1:0] nxt_idx;
	logic                           do_start;
	sfm_pkg::width_t                w_sel;

	// Next state of the train for a tick or a restart from a frame event.
	always_comb begin
		idx_d    = idx_q;
		rem_d    = rem_q;
		pins_d   = pins_q;
		run_d    = run_q;
		nxt_idx  = '0;
		do_start = 1'b0;
		if (ctl.start) begin
			run_d    = 1'b1;
			nxt_idx  = '0;
			do_start = 1'b1;
		end else if (ctl.tick && run_q) begin
			if (rem_q > sfm_pkg::SLOT_W'(1)) begin
				rem_d = rem_q - sfm_pkg::SLOT_W'(1);
			end else begin
				pins_d[idx_q] = 1'b0;
				if (idx_q != sfm_pkg::SLOT_IDX_W'(sfm_pkg::NUM_SLOTS - 1)) begin
					nxt_idx  = idx_q + sfm_pkg::SLOT_IDX_W'(1);
					do_start = 1'b1;
				end else begin
					run_d = 1'b0;
					rem_d = '0;
					idx_d = '0;
				end
			end
		end
		// Slot start: a nonzero width runs twice its value high, else an empty gap low.
		w_sel = slot_w[nxt_idx];
		if (do_start) begin
			idx_d = nxt_idx;
			if (w_sel != '0) begin
				rem_d           = {w_sel, 1'b0};
				pins_d[nxt_idx] = 1'b1;
			end else begin
				rem_d           = empty_ticks;
				pins_d[nxt_idx] = 1'b0;
			end
		end
	end

	assign pins_next    = pins_d;
	assign running_next = run_d;

	// Train state registers; they move only when a word is processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			rem_q  <= '0;
			pins_q <= '0;
			run_q  <= 1'b0;
		end else if (ctl.start || ctl.tick) begin
			idx_q  <= idx_d;
			rem_q  <= rem_d;
			pins_q <= pins_d;
			run_q  <= run_d;
		end
	end

endmodule

@@ src/servo_failsafe_mux_sequencer_top.sv @@
// Servo failsafe mux sequencer: top level with handshake, registers and frame logic.
// Depends on sfm_pkg and instantiates sfm_train.
//
// Each input word is held in an input register, the channel stores, link and
// failsafe flags and pulse train are updated in a single pass, and the result word
// is captured in an output register, so a new word is accepted every cycle while
// the result side takes words. Every word gives exactly one result word showing
// the state after that word. The pulse train counts down one tick per timer-tick
// word; a slot with nonzero width lasts twice the width in ticks with its pin high,
// an empty slot lasts the empty-ticks register value in ticks with its pin low.
// Configuration registers sit at byte addresses 0, 4, ... 24 on the APB port.
module servo_failsafe_mux_sequencer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  sfm_pkg::item_t                item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output sfm_pkg::result_t              result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sfm_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	// Configuration registers.
	logic [sfm_pkg::TMO_W-1:0]  comm_limit_q;
	logic [sfm_pkg::CH_W-1:0]   fs_ch_q;
	logic [sfm_pkg::PW_W-1:0]   fs_min_q;
	logic [sfm_pkg::PW_W-1:0]   fs_max_q;
	logic [sfm_pkg::CH_W-1:0]   mode_ch_q;
	logic [sfm_pkg::PW_W-1:0]   mode_thr_q;
	logic [sfm_pkg::SLOT_W-1:0] empty_ticks_q;
	logic [2:0]                 reg_idx;
	logic                       cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comm_limit_q  <= sfm_pkg::RST_COMM_TIMEOUT;
			fs_ch_q       <= sfm_pkg::RST_FS_CHANNEL;
			fs_min_q      <= sfm_pkg::RST_FS_MIN;
			fs_max_q      <= sfm_pkg::RST_FS_MAX;
			mode_ch_q     <= sfm_pkg::RST_MODE_CHANNEL;
			mode_thr_q    <= sfm_pkg::RST_MODE_THRESH;
			empty_ticks_q <= sfm_pkg::RST_EMPTY_TICKS;
		end else if (cfg_wr) begin
			case (reg_idx)
				sfm_pkg::REG_COMM_TIMEOUT: comm_limit_q  <= pwdata[sfm_pkg::TMO_W-1:0];
				sfm_pkg::REG_FS_CHANNEL:   fs_ch_q       <= pwdata[sfm_pkg::CH_W-1:0];
				sfm_pkg::REG_FS_MIN:       fs_min_q      <= pwdata[sfm_pkg::PW_W-1:0];
				sfm_pkg::REG_FS_MAX:       fs_max_q      <= pwdata[sfm_pkg::PW_W-1:0];
				sfm_pkg::REG_MODE_CHANNEL: mode_ch_q     <= pwdata[sfm_pkg::CH_W-1:0];
				sfm_pkg::REG_MODE_THRESH:  mode_thr_q    <= pwdata[sfm_pkg::PW_W-1:0];
				sfm_pkg::REG_EMPTY_TICKS:  empty_ticks_q <= pwdata[sfm_pkg::SLOT_W-1:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (reg_idx)
			sfm_pkg::REG_COMM_TIMEOUT: prdata = 32'(comm_limit_q);
			sfm_pkg::REG_FS_CHANNEL:   prdata = 32'(fs_ch_q);
			sfm_pkg::REG_FS_MIN:       prdata = 32'(fs_min_q);
			sfm_pkg::REG_FS_MAX:       prdata = 32'(fs_max_q);
			sfm_pkg::REG_MODE_CHANNEL: prdata = 32'(mode_ch_q);
			sfm_pkg::REG_MODE_THRESH:  prdata = 32'(mode_thr_q);
			sfm_pkg::REG_EMPTY_TICKS:  prdata = 32'(empty_ticks_q);
			default:                   prdata = '0;
		endcase
	end

	// Handshake: input register feeding an output register.
	sfm_pkg::item_t item_s1;
	logic           valid_s1;
	logic           out_free;
	logic           advance;
	logic           accept;
	logic           result_valid_q;
	sfm_pkg::result_t result_q;

	assign out_free   = !result_valid_q || !result_stall;
	assign advance    = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	// Block state.
	sfm_pkg::width_t [sfm_pkg::NUM_CHANNELS-1:0] radio_q, radio_d;
	sfm_pkg::width_t [sfm_pkg::NUM_CHANNELS-1:0] outw_q, outw_d;
	sfm_pkg::width_t [3:0]                       duty_q, duty_d;
	logic [sfm_pkg::TMO_W-1:0]                   tmo_q, tmo_d;
	logic link_q, link_d, fs_q, fs_d, pt_q, pt_d, act_q, act_d;

	// Width stored for a channel number; numbers outside 1..8 read as zero.
	function automatic sfm_pkg::width_t chan_width(
		input sfm_pkg::width_t [sfm_pkg::NUM_CHANNELS-1:0] arr,
		input logic [sfm_pkg::CH_W-1:0]                    ch
	);
		logic [sfm_pkg::CH_W-1:0] idx;
		idx = ch - sfm_pkg::CH_W'(1);
		if (ch == '0 || ch > sfm_pkg::CH_W'(sfm_pkg::NUM_CHANNELS)) begin
			return '0;
		end
		return arr[idx[sfm_pkg::CHIDX_W-1:0]];
	endfunction

	sfm_pkg::width_t          fs_w;
	sfm_pkg::width_t          mode_w;
	logic [sfm_pkg::CH_W-1:0] wr_idx;
	logic                     ch_ok;
	logic                     is_frame;
	sfm_pkg::train_ctl_t      train_ctl;

	assign fs_w     = chan_width(radio_q, fs_ch_q);
	assign mode_w   = chan_width(radio_q, mode_ch_q);
	assign wr_idx   = item_s1.channel - sfm_pkg::CH_W'(1);
	assign ch_ok    = item_s1.channel != '0 &&
		item_s1.channel <= sfm_pkg::CH_W'(sfm_pkg::NUM_CHANNELS);
	assign is_frame = item_s1.op == sfm_pkg::OP_FRAME;

	// Next state for the word in the input register.
	always_comb begin
		radio_d = radio_q;
		outw_d  = outw_q;
		duty_d  = duty_q;
		tmo_d   = tmo_q;
		link_d  = link_q;
		fs_d    = fs_q;
		pt_d    = pt_q;
		act_d   = act_q;
		train_ctl.tick  = 1'b0;
		train_ctl.start = 1'b0;
		if (advance) begin
			case (item_s1.op)
				sfm_pkg::OP_TICK: begin
					train_ctl.tick = 1'b1;
				end
				sfm_pkg::OP_FRAME: begin
					// Link timeout, failsafe range and passthrough selection.
					if (tmo_q == comm_limit_q) begin
						link_d = 1'b0;
					end else begin
						link_d = 1'b1;
						tmo_d  = tmo_q + sfm_pkg::TMO_W'(1);
					end
					fs_d = item_s1.failsafe_received && fs_w >= fs_min_q && fs_w <= fs_max_q;
					pt_d = !link_d || (fs_d && mode_w < mode_thr_q);
					act_d = act_q || item_s1.radio_frame_good;
					if (pt_d) begin
						outw_d = radio_q;
					end
					if (act_d) begin
						duty_d[0] = outw_d[6];
						duty_d[1] = outw_d[4];
						duty_d[2] = outw_d[2];
						duty_d[3] = outw_d[0];
						train_ctl.start = 1'b1;
					end
				end
				sfm_pkg::OP_RADIO_WRITE: begin
					if (ch_ok) begin
						radio_d[wr_idx[sfm_pkg::CHIDX_W-1:0]] = item_s1.width;
					end
				end
				sfm_pkg::OP_OUT_WRITE: begin
					if (ch_ok) begin
						outw_d[wr_idx[sfm_pkg::CHIDX_W-1:0]] = item_s1.width;
					end
				end
				sfm_pkg::OP_LINK_MSG: begin
					tmo_d = '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radio_q <= '0;
			outw_q  <= '0;
			duty_q  <= '0;
			tmo_q   <= '0;
			link_q  <= 1'b0;
			fs_q    <= 1'b0;
			pt_q    <= 1'b0;
			act_q   <= 1'b0;
		end else begin
			radio_q <= radio_d;
			outw_q  <= outw_d;
			duty_q  <= duty_d;
			tmo_q   <= tmo_d;
			link_q  <= link_d;
			fs_q    <= fs_d;
			pt_q    <= pt_d;
			act_q   <= act_d;
		end
	end

	// Pulse train for channels 8, 6, 4 and 2, fed with the updated output widths.
	sfm_pkg::width_t [sfm_pkg::NUM_SLOTS-1:0] slot_w;
	logic [sfm_pkg::NUM_SLOTS-1:0]            pins_next;
	logic                                     running_next;

	assign slot_w[0] = outw_d[7];
	assign slot_w[1] = outw_d[5];
	assign slot_w[2] = outw_d[3];
	assign slot_w[3] = outw_d[1];

	sfm_train u_train (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (train_ctl),
		.slot_w       (slot_w),
		.empty_ticks  (empty_ticks_q),
		.pins_next    (pins_next),
		.running_next (running_next)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.pulse_pins     <= pins_next;
			result_q.duty_a         <= duty_d[0];
			result_q.duty_b         <= duty_d[1];
			result_q.duty_c         <= duty_d[2];
			result_q.duty_d         <= duty_d[3];
			result_q.comm_ok        <= link_d;
			result_q.failsafe_good  <= fs_d;
			result_q.passthrough_on <= pt_d;
			result_q.outputs_active <= act_d;
			result_q.sequencing     <= running_next;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	// All pins are low once the train has finished.
	a_idle_pins_low: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.sequencing |-> result.pulse_pins == '0)
		else $error("pulse pin high with no train running");

	// The train only runs after outputs have been enabled.
	a_seq_needs_active: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.sequencing |-> result.outputs_active)
		else $error("train running before outputs active");

	// With the link alive, passthrough requires a good failsafe.
	a_pt_with_link: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.passthrough_on && result.comm_ok |-> result.failsafe_good)
		else $error("passthrough with live link but no failsafe");

	// The input side only stalls when a result word is waiting.
	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && valid_s1)
		else $error("input stalled with empty output register");

	// A frame event that processes with a good frame leaves outputs active.
	a_frame_sets_active: assert property (@(posedge clk) disable iff (!arst_n)
		advance && is_frame && item_s1.radio_frame_good |=> act_q)
		else $error("good frame did not set outputs active");
`endif

endmodule
